@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  // Store geometry
  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 5;

  // Operation codes on the input word
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // Status codes on the result word
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [KEY_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [KEY_BITS-1:0]   min_key;
    logic                         empty_res;
    logic [COUNT_BITS-1:0]        count;
  } out_word_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cap;   // compare incoming key, latch flags
    logic ins;   // open a gap at the boundary and drop the key in
    logic rem;   // close up over the boundary entry
  } cell_ctl_t;

endpackage

@@ design/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// The result word is registered in the output register as the shift state that follows acceptance ends.
// The input is stalled until the shift is done: compare on acceptance, then shift of the cell row.
// The shift waits while an earlier result is still stalled in the output register.
// Reset (rst, synchronous) empties the queue and clears the handshake state, and the
// input is stalled while it is high; key cells are not cleared and are only read below the count.

module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } state_t;

  localparam logic [COUNT_BITS-1:0] DEPTH_CNT = COUNT_BITS'(DEPTH);

  state_t                     state, state_next;
  logic [COUNT_BITS-1:0]      count, count_next;
  logic [1:0]                 op_cmd;
  logic signed [KEY_BITS-1:0] op_key;
  cell_ctl_t                  ctl;
  logic                       accept, go, full, found;
  logic [1:0]                 status_next;
  logic [DEPTH-1:0]           lt_vec, eq_vec;
  logic signed [KEY_BITS-1:0] cell_key [DEPTH];
  logic signed [KEY_BITS-1:0] cell_key_next [DEPTH];

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign go       = (state == S_SHIFT) && !(out_valid && out_stall);
  assign full     = (count == DEPTH_CNT);
  assign found    = |eq_vec;

  assign ctl.cap = accept;
  assign ctl.ins = go && (op_cmd == CMD_INSERT) && !full;
  assign ctl.rem = go && (op_cmd == CMD_REMOVE) && found;

  // Row of cells, lowest key in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       lt_left;
    logic signed [KEY_BITS-1:0] key_left, key_rt;
    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign key_left = '0;
    end else begin : g_mid
      assign lt_left  = lt_vec[i-1];
      assign key_left = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign key_rt = cell_key[i];
    end else begin : g_inner
      assign key_rt = cell_key[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_key    (in_data.key),
      .op_key    (op_key),
      .occ       (COUNT_BITS'(i) < count),
      .lt_prev   (lt_left),
      .key_prev  (key_left),
      .key_right (key_rt),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .key       (cell_key[i]),
      .key_next  (cell_key_next[i])
    );
  end

  // Sequencer and count
  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = STS_OK;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    case (op_cmd)
      CMD_INSERT: begin
        if (full) status_next = STS_FULL;
        else      count_next  = count + 1'b1;
      end
      CMD_REMOVE: begin
        if (found) count_next  = count - 1'b1;
        else       status_next = STS_NOT_FOUND;
      end
      default: begin
        if (!found) status_next = STS_NOT_FOUND;
      end
    endcase
    if (!go) count_next = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Operation held for the shift cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd <= in_data.cmd;
      op_key <= in_data.key;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data.status    <= status_next;
      out_data.min_key   <= (count_next == '0) ? '0 : cell_key_next[0];
      out_data.empty_res <= (count_next == '0);
      out_data.count     <= count_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("count beyond depth");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> $onehot({1'b0, lt_vec} + 1'b1))
    else $error("below-key flags not a prefix, order lost");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> out_valid &&
      (count == $past(count) + 1'b1 || count == $past(count) - 1'b1))
    else $error("count moved without a result or by more than one");

  a_result_after_shift: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid)
    else $error("shift gave no result");

endmodule

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic signed [KEY_BITS-1:0] op_key,
  input  logic                       occ,
  input  logic                       lt_prev,
  input  logic signed [KEY_BITS-1:0] key_prev,
  input  logic signed [KEY_BITS-1:0] key_right,
  output logic                       lt,
  output logic                       eq,
  output logic signed [KEY_BITS-1:0] key,
  output logic signed [KEY_BITS-1:0] key_next
);

  // Cells at or past the boundary (first entry not below the key) shift
  always_comb begin
    key_next = key;
    if (ctl.ins && !lt) begin
      key_next = lt_prev ? op_key : key_prev;
    end else if (ctl.rem && !lt) begin
      key_next = key_right;
    end
  end

  // Compare flags, taken as the word is accepted
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      lt <= occ && (key < in_key);
      eq <= occ && (key == in_key);
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule
